FILE: hdl/rv32d_pkg.sv
`timescale 1ns / 1ps

package rv32d_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned KindW = 6;
  localparam int unsigned RegW  = 5;

  localparam logic [WordW-1:0] HALT_WORD = 32'h0ff0_0513;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_ALUI   = 7'h13;
  localparam logic [6:0] OP_ALUR   = 7'h33;

  localparam logic [2:0] F3_SLL = 3'd1;
  localparam logic [2:0] F3_SRL = 3'd5;

  localparam logic [KindW-1:0] K_UNKNOWN = 6'd0;
  localparam logic [KindW-1:0] K_HALT    = 6'd1;
  localparam logic [KindW-1:0] K_LUI     = 6'd2;
  localparam logic [KindW-1:0] K_AUIPC   = 6'd3;
  localparam logic [KindW-1:0] K_JAL     = 6'd4;
  localparam logic [KindW-1:0] K_JALR    = 6'd5;
  localparam logic [KindW-1:0] K_BEQ     = 6'd6;
  localparam logic [KindW-1:0] K_BNE     = 6'd7;
  localparam logic [KindW-1:0] K_BLT     = 6'd8;
  localparam logic [KindW-1:0] K_BGE     = 6'd9;
  localparam logic [KindW-1:0] K_BLTU    = 6'd10;
  localparam logic [KindW-1:0] K_BGEU    = 6'd11;
  localparam logic [KindW-1:0] K_LB      = 6'd12;
  localparam logic [KindW-1:0] K_LH      = 6'd13;
  localparam logic [KindW-1:0] K_LW      = 6'd14;
  localparam logic [KindW-1:0] K_LBU     = 6'd15;
  localparam logic [KindW-1:0] K_LHU     = 6'd16;
  localparam logic [KindW-1:0] K_SB      = 6'd17;
  localparam logic [KindW-1:0] K_SH      = 6'd18;
  localparam logic [KindW-1:0] K_SW      = 6'd19;
  localparam logic [KindW-1:0] K_ADDI    = 6'd20;
  localparam logic [KindW-1:0] K_SLTI    = 6'd21;
  localparam logic [KindW-1:0] K_SLTIU   = 6'd22;
  localparam logic [KindW-1:0] K_XORI    = 6'd23;
  localparam logic [KindW-1:0] K_ORI     = 6'd24;
  localparam logic [KindW-1:0] K_ANDI    = 6'd25;
  localparam logic [KindW-1:0] K_SLLI    = 6'd26;
  localparam logic [KindW-1:0] K_SRLI    = 6'd27;
  localparam logic [KindW-1:0] K_ADD     = 6'd28;
  localparam logic [KindW-1:0] K_SUB     = 6'd29;
  localparam logic [KindW-1:0] K_SLL     = 6'd30;
  localparam logic [KindW-1:0] K_SLT     = 6'd31;
  localparam logic [KindW-1:0] K_SLTU    = 6'd32;
  localparam logic [KindW-1:0] K_XOR     = 6'd33;
  localparam logic [KindW-1:0] K_SRL     = 6'd34;
  localparam logic [KindW-1:0] K_SRA     = 6'd35;
  localparam logic [KindW-1:0] K_OR      = 6'd36;
  localparam logic [KindW-1:0] K_AND     = 6'd37;
  localparam logic [KindW-1:0] K_SRAI    = 6'd38;

  typedef struct packed {
    logic [KindW-1:0]        kind;
    logic [RegW-1:0]         rd;
    logic [RegW-1:0]         rs1;
    logic [RegW-1:0]         rs2;
    logic signed [WordW-1:0] imm;
  } dec_t;

  function automatic logic [KindW-1:0] branch_kind(input logic [2:0] f3);
    logic [KindW-1:0] k;
    unique case (f3)
      3'd0:    k = K_BEQ;
      3'd1:    k = K_BNE;
      3'd4:    k = K_BLT;
      3'd5:    k = K_BGE;
      3'd6:    k = K_BLTU;
      3'd7:    k = K_BGEU;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [KindW-1:0] load_kind(input logic [2:0] f3);
    logic [KindW-1:0] k;
    unique case (f3)
      3'd0:    k = K_LB;
      3'd1:    k = K_LH;
      3'd2:    k = K_LW;
      3'd4:    k = K_LBU;
      3'd5:    k = K_LHU;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [KindW-1:0] store_kind(input logic [2:0] f3);
    logic [KindW-1:0] k;
    unique case (f3)
      3'd0:    k = K_SB;
      3'd1:    k = K_SH;
      3'd2:    k = K_SW;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [KindW-1:0] alui_kind(input logic [2:0] f3, input logic b30);
    logic [KindW-1:0] k;
    unique case (f3)
      3'd0:    k = K_ADDI;
      3'd1:    k = K_SLLI;
      3'd2:    k = K_SLTI;
      3'd3:    k = K_SLTIU;
      3'd4:    k = K_XORI;
      3'd5:    k = b30 ? K_SRAI : K_SRLI;
      3'd6:    k = K_ORI;
      default: k = K_ANDI;
    endcase
    return k;
  endfunction

  function automatic logic [KindW-1:0] alur_kind(input logic [2:0] f3, input logic b30);
    logic [KindW-1:0] k;
    unique case (f3)
      3'd0:    k = b30 ? K_SUB : K_ADD;
      3'd1:    k = K_SLL;
      3'd2:    k = K_SLT;
      3'd3:    k = K_SLTU;
      3'd4:    k = K_XOR;
      3'd5:    k = b30 ? K_SRA : K_SRL;
      3'd6:    k = K_OR;
      default: k = K_AND;
    endcase
    return k;
  endfunction

endpackage

FILE: hdl/rv32d_decode.sv
`timescale 1ns / 1ps

module rv32d_decode (
  input  logic [rv32d_pkg::WordW-1:0] word,
  output rv32d_pkg::dec_t             dec
);

  logic [6:0]                        opc;
  logic [2:0]                        f3;
  logic                              b30;
  logic [rv32d_pkg::WordW-1:0]       imm_i;
  logic [rv32d_pkg::WordW-1:0]       imm_u;
  logic [rv32d_pkg::WordW-1:0]       imm_j;
  logic [rv32d_pkg::WordW-1:0]       imm_b;
  logic [rv32d_pkg::WordW-1:0]       imm_s;
  logic [rv32d_pkg::WordW-1:0]       imm_sh;
  rv32d_pkg::dec_t                   d;

  assign opc    = word[6:0];
  assign f3     = word[14:12];
  assign b30    = word[30];
  assign imm_i  = {{20{word[31]}}, word[31:20]};
  assign imm_u  = {word[31:12], 12'd0};
  assign imm_j  = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
  assign imm_b  = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign imm_s  = {{20{word[31]}}, word[31:25], word[11:7]};
  assign imm_sh = {27'd0, word[24:20]};

  always_comb begin
    d = '0;
    if (word == rv32d_pkg::HALT_WORD) begin
      d.kind = rv32d_pkg::K_HALT;
    end else begin
      unique case (opc)
        rv32d_pkg::OP_LUI: begin
          d.kind = rv32d_pkg::K_LUI;
          d.rd   = word[11:7];
          d.imm  = imm_u;
        end
        rv32d_pkg::OP_AUIPC: begin
          d.kind = rv32d_pkg::K_AUIPC;
          d.rd   = word[11:7];
          d.imm  = imm_u;
        end
        rv32d_pkg::OP_JAL: begin
          d.kind = rv32d_pkg::K_JAL;
          d.rd   = word[11:7];
          d.imm  = imm_j;
        end
        rv32d_pkg::OP_JALR: begin
          d.kind = rv32d_pkg::K_JALR;
          d.rd   = word[11:7];
          d.rs1  = word[19:15];
          d.imm  = imm_i;
        end
        rv32d_pkg::OP_BRANCH: begin
          d.kind = rv32d_pkg::branch_kind(f3);
          d.rs1  = word[19:15];
          d.rs2  = word[24:20];
          d.imm  = imm_b;
        end
        rv32d_pkg::OP_LOAD: begin
          d.kind = rv32d_pkg::load_kind(f3);
          d.rd   = word[11:7];
          d.rs1  = word[19:15];
          d.imm  = imm_i;
        end
        rv32d_pkg::OP_STORE: begin
          d.kind = rv32d_pkg::store_kind(f3);
          d.rs1  = word[19:15];
          d.rs2  = word[24:20];
          d.imm  = imm_s;
        end
        rv32d_pkg::OP_ALUI: begin
          d.kind = rv32d_pkg::alui_kind(f3, b30);
          d.rd   = word[11:7];
          d.rs1  = word[19:15];
          d.imm  = (f3 == rv32d_pkg::F3_SLL || f3 == rv32d_pkg::F3_SRL) ? imm_sh : imm_i;
        end
        rv32d_pkg::OP_ALUR: begin
          d.kind = rv32d_pkg::alur_kind(f3, b30);
          d.rd   = word[11:7];
          d.rs1  = word[19:15];
          d.rs2  = word[24:20];
        end
        default: begin
          d = '0;
        end
      endcase
    end
    // An encoding with no meaning reports nothing but its zero kind.
    if (d.kind == rv32d_pkg::K_UNKNOWN) begin
      d = '0;
    end
  end

  assign dec = d;

endmodule

FILE: hdl/rv32i_instruction_decoder.sv
`timescale 1ns / 1ps

// Channel   Ports                                      Handshake
// request   start, busy, in_instr_word                 start & !busy
// result    out_valid, out_kind, out_dest_reg,         out_valid, one cycle
//           out_src_reg_one, out_src_reg_two,
//           out_immediate
//
// A request is taken in every cycle; busy is always low.
// The word is registered in in_word_r, decoded in one pass, and the result is
// registered in res_r, with out_valid high for exactly one cycle.
// Synchronous active-low reset clears both valid flags; no result follows
// a request taken before reset. The receiver cannot stall the result.

module rv32i_instruction_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [rv32d_pkg::WordW-1:0]        in_instr_word,
  output logic                               out_valid,
  output logic [rv32d_pkg::KindW-1:0]        out_kind,
  output logic [rv32d_pkg::RegW-1:0]         out_dest_reg,
  output logic [rv32d_pkg::RegW-1:0]         out_src_reg_one,
  output logic [rv32d_pkg::RegW-1:0]         out_src_reg_two,
  output logic signed [rv32d_pkg::WordW-1:0] out_immediate
);

  logic                        in_valid_r;
  logic [rv32d_pkg::WordW-1:0] in_word_r;
  logic                        out_valid_r;
  rv32d_pkg::dec_t             res_r;
  rv32d_pkg::dec_t             res_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      in_word_r <= in_instr_word;
    end
    if (in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  rv32d_decode u_decode (
    .word (in_word_r),
    .dec  (res_nxt)
  );

  assign out_valid       = out_valid_r;
  assign out_kind        = res_r.kind;
  assign out_dest_reg    = res_r.rd;
  assign out_src_reg_one = res_r.rs1;
  assign out_src_reg_two = res_r.rs2;
  assign out_immediate   = res_r.imm;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> ##1 out_valid)
    else $error("Result missing two cycles after a request.");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid_r))
    else $error("Result without a decoded request.");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("Result strobe right after reset.");

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == rv32d_pkg::K_UNKNOWN || out_kind == rv32d_pkg::K_HALT))
      |-> (out_dest_reg == '0 && out_src_reg_one == '0 && out_src_reg_two == '0
           && out_immediate == '0))
    else $error("Unknown or halt result carries nonzero fields.");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= rv32d_pkg::K_SRAI)
    else $error("Result kind out of range.");
`endif

endmodule

FILE: dv/rv32i_instruction_decoder_tb.sv
`timescale 1ns / 1ps

module rv32i_instruction_decoder_tb;

  import rv32d_pkg::*;

  localparam int unsigned IdleLimit = 200;
  localparam int unsigned RandomWords = 850;

  class decode_scoreboard;
    dec_t expected_q[$];
    int unsigned requests;
    int unsigned results;
    int unsigned mismatches;
    bit kind_seen[64];

    function dec_t decode_word(logic [WordW-1:0] w);
      dec_t r;
      logic [6:0] opc;
      logic [2:0] f3;
      logic b30;
      logic [WordW-1:0] imm_i;
      r = '0;
      opc = w[6:0];
      f3 = w[14:12];
      b30 = w[30];
      imm_i = {{20{w[31]}}, w[31:20]};
      if (w == HALT_WORD) begin
        r.kind = K_HALT;
      end else begin
        case (opc)
          OP_LUI, OP_AUIPC: begin
            r.kind = (opc == OP_LUI) ? K_LUI : K_AUIPC;
            r.rd = w[11:7];
            r.imm = {w[31:12], 12'b0};
          end
          OP_JAL: begin
            r.kind = K_JAL;
            r.rd = w[11:7];
            r.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
          end
          OP_JALR: begin
            r.kind = K_JALR;
            r.rd = w[11:7];
            r.rs1 = w[19:15];
            r.imm = imm_i;
          end
          OP_BRANCH: begin
            case (f3)
              3'd0: r.kind = K_BEQ;
              3'd1: r.kind = K_BNE;
              3'd4: r.kind = K_BLT;
              3'd5: r.kind = K_BGE;
              3'd6: r.kind = K_BLTU;
              3'd7: r.kind = K_BGEU;
              default: r.kind = K_UNKNOWN;
            endcase
            r.rs1 = w[19:15];
            r.rs2 = w[24:20];
            r.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
          end
          OP_LOAD: begin
            case (f3)
              3'd0: r.kind = K_LB;
              3'd1: r.kind = K_LH;
              3'd2: r.kind = K_LW;
              3'd4: r.kind = K_LBU;
              3'd5: r.kind = K_LHU;
              default: r.kind = K_UNKNOWN;
            endcase
            r.rd = w[11:7];
            r.rs1 = w[19:15];
            r.imm = imm_i;
          end
          OP_STORE: begin
            case (f3)
              3'd0: r.kind = K_SB;
              3'd1: r.kind = K_SH;
              3'd2: r.kind = K_SW;
              default: r.kind = K_UNKNOWN;
            endcase
            r.rs1 = w[19:15];
            r.rs2 = w[24:20];
            r.imm = {{20{w[31]}}, w[31:25], w[11:7]};
          end
          OP_ALUI: begin
            case (f3)
              3'd0: r.kind = K_ADDI;
              3'd1: r.kind = K_SLLI;
              3'd2: r.kind = K_SLTI;
              3'd3: r.kind = K_SLTIU;
              3'd4: r.kind = K_XORI;
              3'd5: r.kind = b30 ? K_SRAI : K_SRLI;
              3'd6: r.kind = K_ORI;
              default: r.kind = K_ANDI;
            endcase
            r.rd = w[11:7];
            r.rs1 = w[19:15];
            r.imm = (f3 == F3_SLL || f3 == F3_SRL) ? {27'b0, w[24:20]} : imm_i;
          end
          OP_ALUR: begin
            case (f3)
              3'd0: r.kind = b30 ? K_SUB : K_ADD;
              3'd1: r.kind = K_SLL;
              3'd2: r.kind = K_SLT;
              3'd3: r.kind = K_SLTU;
              3'd4: r.kind = K_XOR;
              3'd5: r.kind = b30 ? K_SRA : K_SRL;
              3'd6: r.kind = K_OR;
              default: r.kind = K_AND;
            endcase
            r.rd = w[11:7];
            r.rs1 = w[19:15];
            r.rs2 = w[24:20];
          end
          default: r.kind = K_UNKNOWN;
        endcase
      end
      if (r.kind == K_UNKNOWN) begin
        r = '0;
      end
      return r;
    endfunction

    function void note_request(logic [WordW-1:0] w);
      dec_t d;
      d = decode_word(w);
      expected_q.push_back(d);
      kind_seen[d.kind] = 1'b1;
      requests++;
    endfunction

    function void check_result(dec_t got);
      dec_t want;
      results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] Unexpected result: kind %0d rd %0d rs1 %0d rs2 %0d imm %h",
                   $time, got.kind, got.rd, got.rs1, got.rs2, got.imm);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.rd !== want.rd || got.rs1 !== want.rs1 ||
          got.rs2 !== want.rs2 || got.imm !== want.imm) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] Mismatch: expected kind %0d rd %0d rs1 %0d rs2 %0d imm %h",
                   $time, want.kind, want.rd, want.rs1, want.rs2, want.imm);
          $display("[%0t]           actual   kind %0d rd %0d rs1 %0d rs2 %0d imm %h",
                   $time, got.kind, got.rd, got.rs1, got.rs2, got.imm);
        end
      end
    endfunction

    function int unsigned kinds_covered();
      int unsigned n;
      n = 0;
      for (int i = 0; i < 64; i++) begin
        if (kind_seen[i]) n++;
      end
      return n;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [WordW-1:0] in_instr_word;
  logic out_valid;
  logic [KindW-1:0] out_kind;
  logic [RegW-1:0] out_dest_reg;
  logic [RegW-1:0] out_src_reg_one;
  logic [RegW-1:0] out_src_reg_two;
  logic signed [WordW-1:0] out_immediate;

  decode_scoreboard sb = new();
  logic [WordW-1:0] word_q[$];
  int unsigned idle_cycles;

  rv32i_instruction_decoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_instr_word(in_instr_word),
    .out_valid(out_valid),
    .out_kind(out_kind),
    .out_dest_reg(out_dest_reg),
    .out_src_reg_one(out_src_reg_one),
    .out_src_reg_two(out_src_reg_two),
    .out_immediate(out_immediate)
  );

  initial clk = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    dec_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.kind = out_kind;
        got.rd = out_dest_reg;
        got.rs1 = out_src_reg_one;
        got.rs2 = out_src_reg_two;
        got.imm = out_immediate;
        sb.check_result(got);
      end
      if (start && !busy) begin
        sb.note_request(in_instr_word);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d cycles without activity.", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [WordW-1:0] random_word();
    logic [WordW-1:0] w;
    logic [6:0] opcodes[9];
    opcodes = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH,
                OP_LOAD, OP_STORE, OP_ALUI, OP_ALUR};
    w = $urandom();
    case ($urandom_range(0, 19))
      0: w = HALT_WORD;
      1, 2: ;
      default: w[6:0] = opcodes[$urandom_range(0, 8)];
    endcase
    return w;
  endfunction

  task automatic send_word(input logic [WordW-1:0] w);
    start <= 1'b1;
    in_instr_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drive_requests();
    int unsigned burst;
    int unsigned gap;
    while (word_q.size() != 0) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      for (int unsigned i = 0; i < burst && word_q.size() != 0; i++) begin
        send_word(word_q.pop_front());
      end
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_instr_word = '0;

    word_q = '{HALT_WORD, 32'h0ff0_0512, 32'h0ff0_0593, 32'h0000_0000, 32'hffff_ffff,
               32'hffff_ffb7, 32'h0000_0017, 32'hffff_ffef, 32'h7fff_f06f,
               32'h8000_006f, 32'hffff_ffe7, 32'hffff_ffe3, 32'h0000_2063,
               32'h7fff_3fe3, 32'hffff_8f83, 32'h0000_3003, 32'hffff_ef83,
               32'hffff_afa3, 32'h0000_4023, 32'h41f0_5013, 32'hbff0_5013,
               32'h4000_1093, 32'h8000_0013, 32'h4000_0033, 32'hc1ff_dfb3,
               32'hffff_ffb3};
    for (int i = 0; i < RandomWords; i++) begin
      word_q.push_back(random_word());
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_requests();
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Decoded %0d instruction words into %0d results, %0d mismatches.",
             sb.requests, sb.results, sb.mismatches);
    $display("Instruction kinds exercised: %0d of 39, halt and unknown included.",
             sb.kinds_covered());
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rv32d_pkg.sv
hdl/rv32d_decode.sv
hdl/rv32i_instruction_decoder.sv
dv/rv32i_instruction_decoder_tb.sv
